// ===== rtl/pgcp_pkg.sv =====
// shared types and constants of the penalized greedy code picker
`default_nettype none

package pgcp_pkg;

   // field widths
   localparam int CODE_W     = 11;
   localparam int LOGIT_W    = 32;
   localparam int ACTION_W   = 2;
   localparam int STATUS_W   = 2;
   localparam int FRAME_W    = 12;
   localparam int GAIN_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int CODE_SPAN  = 2048;

   // seen map epoch tags
   localparam int EPOCH_W = 8;

   // front to back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // penalty arithmetic
   localparam int MAG_W        = LOGIT_W + 1;
   localparam int PROD_W       = MAG_W + GAIN_W;
   localparam int GAIN_SHIFT   = 14;
   localparam int RECIP_SHIFT  = 16;
   localparam logic [PROD_W:0] ROUND_BIAS = (PROD_W + 1)'((1 << GAIN_SHIFT) - 1);

   // action codes
   localparam logic [ACTION_W-1:0] ACTION_START = 2'd0;
   localparam logic [ACTION_W-1:0] ACTION_LOGIT = 2'd1;
   localparam logic [ACTION_W-1:0] ACTION_CLOSE = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_CODE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EOS   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LIMIT = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PENALTY_GAIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PENALTY_RECIP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_FRAMES    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FRAMES    = 2'd3;

   // register reset values
   localparam logic [GAIN_W-1:0]  GAIN_RESET       = 16'd18842;
   localparam logic [GAIN_W-1:0]  RECIP_RESET      = 16'd56987;
   localparam logic [FRAME_W-1:0] MIN_FRAMES_RESET = 12'd2;
   localparam logic [FRAME_W-1:0] MAX_FRAMES_RESET = 12'd4095;

   localparam logic signed [LOGIT_W-1:0] LOGIT_MIN = {1'b1, {(LOGIT_W - 1){1'b0}}};

   typedef enum logic [1:0] {
      OP_START,
      OP_LOGIT,
      OP_CLOSE
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic [CODE_W-1:0]          code;
      logic signed [LOGIT_W-1:0]  logit;
   } item_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  penalty_gain;
      logic [GAIN_W-1:0]  penalty_recip;
      logic [FRAME_W-1:0] min_frames;
      logic [FRAME_W-1:0] max_frames;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== rtl/pgcp_front.sv =====
// front end: takes request words, drops ignored ones, tags the rest with an op
`default_nettype none

module pgcp_front #(
   parameter int VOCAB_SIZE = 2048
) (
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [pgcp_pkg::ACTION_W-1:0]     req_action,
   input  wire logic [pgcp_pkg::CODE_W-1:0]       req_code_index,
   input  wire logic signed [pgcp_pkg::LOGIT_W-1:0] req_logit,
   input  wire pgcp_pkg::queue_status_type        q_status,
   input  wire logic                              clearing,
   output logic                                   push,
   output pgcp_pkg::item_type                     push_item
);
   import pgcp_pkg::*;

   logic keep;
   logic in_range;

   assign req_stall = q_status.full | clearing;
   assign in_range  = 32'(req_code_index) < 32'(VOCAB_SIZE);

   always_comb begin
      keep            = 1'b0;
      push_item.op    = OP_LOGIT;
      push_item.code  = req_code_index;
      push_item.logit = req_logit;
      case (req_action)
         ACTION_START: begin
            keep         = 1'b1;
            push_item.op = OP_START;
         end
         ACTION_LOGIT: begin
            // codes past the vocabulary never reach the back end
            keep         = in_range;
            push_item.op = OP_LOGIT;
         end
         ACTION_CLOSE: begin
            keep         = 1'b1;
            push_item.op = OP_CLOSE;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push = req_valid & ~req_stall & keep;

endmodule

`default_nettype wire

// ===== rtl/pgcp_queue.sv =====
// short fifo between front and back
`default_nettype none

module pgcp_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire pgcp_pkg::item_type         push_item,
   input  wire logic                       pop,
   output pgcp_pkg::item_type              pop_item,
   output pgcp_pkg::queue_status_type      status
);
   import pgcp_pkg::*;

   item_type slot_mem [QUEUE_DEPTH];

   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + QUEUE_CW'(1);
         2'b01:   count_in = count_ff - QUEUE_CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_mem[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item     = slot_mem[rd_ptr_ff];
   assign status.full  = count_ff == QUEUE_CW'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;

endmodule

`default_nettype wire

// ===== rtl/pgcp_back.sv =====
// back end: seen map lookup, penalty multiply, argmax, frame close and result register
`default_nettype none

module pgcp_back #(
   parameter int VOCAB_SIZE       = 2048,
   parameter int FRAME_COUNT_BITS = 12
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pgcp_pkg::cfg_type             cfg,
   input  wire pgcp_pkg::queue_status_type    q_status,
   input  wire pgcp_pkg::item_type            q_item,
   output logic                               q_pop,
   output logic                               clearing,
   input  wire logic                          rsp_stall,
   output logic                               rsp_valid,
   output logic [pgcp_pkg::CODE_W-1:0]        rsp_chosen_code,
   output logic [pgcp_pkg::STATUS_W-1:0]      rsp_status,
   output logic [pgcp_pkg::FRAME_W-1:0]       rsp_frame_number
);
   import pgcp_pkg::*;

   localparam int MAP_DEPTH = (VOCAB_SIZE < CODE_SPAN) ? VOCAB_SIZE : CODE_SPAN;
   localparam int MAP_AW    = $clog2(MAP_DEPTH);
   localparam int CMP_W     = ((FRAME_COUNT_BITS > FRAME_W) ? FRAME_COUNT_BITS : FRAME_W) + 1;
   localparam logic [MAP_AW-1:0]  MAP_LAST    = MAP_AW'(MAP_DEPTH - 1);
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

   // seen map: an entry is seen when its tag equals the current epoch
   logic [EPOCH_W-1:0] seen_mem [MAP_DEPTH];
   logic [EPOCH_W-1:0] rd_tag_ff;

   logic                clearing_ff, clearing_in;
   logic [MAP_AW-1:0]   clear_ptr_ff, clear_ptr_in;
   logic [EPOCH_W-1:0]  epoch_ff, epoch_in;

   // stage 1: tag read back, product formed
   logic      s1_valid_ff, s1_valid_in;
   item_type  s1_item_ff, s1_item_in;
   logic      s1_hit_ff, s1_hit_in;
   logic      s1_kill_ff, s1_kill_in;

   // stage 2: product held, penalty finished
   logic               s2_valid_ff, s2_valid_in;
   item_type           s2_item_ff, s2_item_in;
   logic               s2_seen_ff, s2_seen_in;
   logic               s2_neg_ff, s2_neg_in;
   logic [PROD_W-1:0]  s2_prod_ff, s2_prod_in;

   // stage 3: compare and close
   logic                       s3_valid_ff, s3_valid_in;
   item_type                   s3_item_ff, s3_item_in;
   logic                       s3_seen_ff, s3_seen_in;
   logic signed [LOGIT_W-1:0]  s3_pen_ff, s3_pen_in;

   logic signed [LOGIT_W-1:0]   best_value_ff, best_value_in;
   logic [CODE_W-1:0]           best_code_ff, best_code_in;
   logic [FRAME_COUNT_BITS-1:0] frame_count_ff, frame_count_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]    rsp_code_ff, rsp_code_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [FRAME_W-1:0]   rsp_frame_ff, rsp_frame_in;

   logic                       advance;
   logic                       exec;
   logic                       s3_close;
   logic                       start_exec;
   logic                       mark;
   logic [MAP_AW-1:0]          mark_addr;
   logic                       hit_q, hit_s1, hit_s2;
   logic                       s1_seen;
   logic                       s1_neg;
   logic [MAG_W-1:0]           s1_mag;
   logic [GAIN_W-1:0]          s1_factor;
   logic [PROD_W:0]            s2_rounded;
   logic [PROD_W-GAIN_SHIFT:0] s2_quot;
   logic signed [LOGIT_W-1:0]  s2_pen_neg;
   logic signed [LOGIT_W-1:0]  s2_pen_pos;
   logic signed [LOGIT_W-1:0]  s3_value;
   logic                       s3_better;
   logic [CMP_W-1:0]           frame_x;
   logic [CMP_W-1:0]           frame_next_x;
   logic                       eos_win;
   logic                       at_limit;

   // pipeline moves as a whole; only a seen map sweep or a close held by a full result register stops it
   assign s3_close   = s3_valid_ff && (s3_item_ff.op == OP_CLOSE);
   assign advance    = !clearing_ff && !(s3_close && rsp_valid_ff && rsp_stall);
   assign exec       = advance && s3_valid_ff;
   assign q_pop      = advance && !q_status.empty;
   assign start_exec = exec && (s3_item_ff.op == OP_START);
   assign clearing   = clearing_ff;

   assign frame_x      = CMP_W'(frame_count_ff);
   assign frame_next_x = frame_x + CMP_W'(1);
   assign eos_win      = (frame_x >= CMP_W'(cfg.min_frames))
                         && (s3_item_ff.logit > best_value_ff);
   assign at_limit     = frame_next_x >= CMP_W'(cfg.max_frames);

   assign mark      = exec && s3_close && !eos_win;
   assign mark_addr = best_code_ff[MAP_AW-1:0];

   // forward a mark to younger items whose tag read is already behind it
   assign hit_q  = mark && (q_item.code[MAP_AW-1:0] == mark_addr);
   assign hit_s1 = mark && (s1_item_ff.code[MAP_AW-1:0] == mark_addr);
   assign hit_s2 = mark && (s2_item_ff.code[MAP_AW-1:0] == mark_addr);

   // stage 1 math
   assign s1_seen   = ((rd_tag_ff == epoch_ff) && !s1_kill_ff) || s1_hit_ff;
   assign s1_neg    = s1_item_ff.logit[LOGIT_W-1];
   assign s1_mag    = s1_neg ? MAG_W'(0) - {s1_item_ff.logit[LOGIT_W-1], s1_item_ff.logit}
                             : {1'b0, s1_item_ff.logit};
   assign s1_factor = s1_neg ? cfg.penalty_gain : cfg.penalty_recip;

   // stage 2 math: negative rounds toward minus infinity and saturates
   assign s2_rounded = {1'b0, s2_prod_ff} + ROUND_BIAS;
   assign s2_quot    = s2_rounded[PROD_W:GAIN_SHIFT];
   assign s2_pen_neg = (s2_quot[PROD_W-GAIN_SHIFT:LOGIT_W-1] != '0)
                       ? LOGIT_MIN : LOGIT_W'(0) - s2_quot[LOGIT_W-1:0];
   assign s2_pen_pos = s2_prod_ff[RECIP_SHIFT+LOGIT_W-1:RECIP_SHIFT];

   // stage 3 math
   assign s3_value  = s3_seen_ff ? s3_pen_ff : s3_item_ff.logit;
   assign s3_better = s3_value > best_value_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      s1_hit_in   = s1_hit_ff;
      s1_kill_in  = s1_kill_ff;
      s2_valid_in = s2_valid_ff;
      s2_item_in  = s2_item_ff;
      s2_seen_in  = s2_seen_ff;
      s2_neg_in   = s2_neg_ff;
      s2_prod_in  = s2_prod_ff;
      s3_valid_in = s3_valid_ff;
      s3_item_in  = s3_item_ff;
      s3_seen_in  = s3_seen_ff;
      s3_pen_in   = s3_pen_ff;
      if (advance) begin
         s1_valid_in = q_pop;
         s1_item_in  = q_item;
         s1_hit_in   = hit_q;
         s1_kill_in  = start_exec;
         s2_valid_in = s1_valid_ff;
         s2_item_in  = s1_item_ff;
         s2_seen_in  = (s1_seen || hit_s1) && !start_exec;
         s2_neg_in   = s1_neg;
         s2_prod_in  = PROD_W'(s1_mag) * PROD_W'(s1_factor);
         s3_valid_in = s2_valid_ff;
         s3_item_in  = s2_item_ff;
         s3_seen_in  = (s2_seen_ff || hit_s2) && !start_exec;
         s3_pen_in   = s2_neg_ff ? s2_pen_neg : s2_pen_pos;
      end
   end

   always_comb begin
      best_value_in  = best_value_ff;
      best_code_in   = best_code_ff;
      frame_count_in = frame_count_ff;
      epoch_in       = epoch_ff;
      clearing_in    = clearing_ff;
      clear_ptr_in   = clear_ptr_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_code_in    = rsp_code_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_frame_in   = rsp_frame_ff;
      if (clearing_ff) begin
         clear_ptr_in = clear_ptr_ff + MAP_AW'(1);
         if (clear_ptr_ff == MAP_LAST) begin
            clearing_in = 1'b0;
         end
      end
      if (exec) begin
         case (s3_item_ff.op)
            OP_START: begin
               best_value_in  = LOGIT_MIN;
               best_code_in   = '0;
               frame_count_in = '0;
               // new epoch forgets every mark; a wrapped epoch needs a real sweep
               if (epoch_ff == EPOCH_LAST) begin
                  epoch_in     = EPOCH_FIRST;
                  clearing_in  = 1'b1;
                  clear_ptr_in = '0;
               end else begin
                  epoch_in = epoch_ff + EPOCH_W'(1);
               end
            end
            OP_LOGIT: begin
               if (s3_better) begin
                  best_value_in = s3_value;
                  best_code_in  = s3_item_ff.code;
               end
            end
            OP_CLOSE: begin
               rsp_valid_in  = 1'b1;
               rsp_frame_in  = frame_x[FRAME_W-1:0];
               best_value_in = LOGIT_MIN;
               best_code_in  = '0;
               if (eos_win) begin
                  rsp_code_in    = '0;
                  rsp_status_in  = STATUS_EOS;
                  frame_count_in = '0;
               end else if (at_limit) begin
                  rsp_code_in    = best_code_ff;
                  rsp_status_in  = STATUS_LIMIT;
                  frame_count_in = '0;
               end else begin
                  rsp_code_in    = best_code_ff;
                  rsp_status_in  = STATUS_CODE;
                  frame_count_in = frame_next_x[FRAME_COUNT_BITS-1:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff    <= 1'b1;
         clear_ptr_ff   <= '0;
         epoch_ff       <= EPOCH_FIRST;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         best_value_ff  <= LOGIT_MIN;
         best_code_ff   <= '0;
         frame_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         clearing_ff    <= clearing_in;
         clear_ptr_ff   <= clear_ptr_in;
         epoch_ff       <= epoch_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         s3_valid_ff    <= s3_valid_in;
         best_value_ff  <= best_value_in;
         best_code_ff   <= best_code_in;
         frame_count_ff <= frame_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff    <= s1_item_in;
      s1_hit_ff     <= s1_hit_in;
      s1_kill_ff    <= s1_kill_in;
      s2_item_ff    <= s2_item_in;
      s2_seen_ff    <= s2_seen_in;
      s2_neg_ff     <= s2_neg_in;
      s2_prod_ff    <= s2_prod_in;
      s3_item_ff    <= s3_item_in;
      s3_seen_ff    <= s3_seen_in;
      s3_pen_ff     <= s3_pen_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_status_ff <= rsp_status_in;
      rsp_frame_ff  <= rsp_frame_in;
   end

   // one write port (sweep or mark), one registered read port
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         seen_mem[clear_ptr_ff] <= '0;
      end else if (mark) begin
         seen_mem[mark_addr] <= epoch_ff;
      end
      if (advance) begin
         rd_tag_ff <= seen_mem[q_item.code[MAP_AW-1:0]];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chosen_code  = rsp_code_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_frame_number = rsp_frame_ff;

endmodule

`default_nettype wire

// ===== rtl/penalized_greedy_code_picker.sv =====
// top level of the penalized greedy code picker: registers, front, queue, back
//
//   channel  dir  handshake              payload
//   req      in   req_valid / req_stall  req_action, req_code_index, req_logit
//   rsp      out  rsp_valid / rsp_stall  rsp_chosen_code, rsp_status, rsp_frame_number
//   csr      in   csr_wen                csr_index, csr_wdata
//
// one word accepted per cycle while req_stall is low; a closing word passes the queue,
// tag read, multiply, penalty, compare and result register before its result shows
// the seen map is one tag per code, one write and one read port; after reset and after
// every 255th start word a sweep clears all min(VOCAB_SIZE, 2048) tags, req_stall held high
// a stalled result freezes the back pipeline at the next close; the queue then fills and raises req_stall
`default_nettype none

module penalized_greedy_code_picker #(
   parameter int VOCAB_SIZE       = 2048,
   parameter int FRAME_COUNT_BITS = 12
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request words
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [pgcp_pkg::ACTION_W-1:0]       req_action,
   input  wire logic [pgcp_pkg::CODE_W-1:0]         req_code_index,
   input  wire logic signed [pgcp_pkg::LOGIT_W-1:0] req_logit,
   // result words
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [pgcp_pkg::CODE_W-1:0]              rsp_chosen_code,
   output logic [pgcp_pkg::STATUS_W-1:0]            rsp_status,
   output logic [pgcp_pkg::FRAME_W-1:0]             rsp_frame_number,
   // register writes
   input  wire logic                                csr_wen,
   input  wire logic [pgcp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [pgcp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pgcp_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   queue_status_type q_status;
   item_type         push_item;
   item_type         q_item;
   logic             push;
   logic             q_pop;
   logic             clearing;

   // config registers, to be written only while the block is quiet; the block does not enforce this
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_PENALTY_GAIN:  cfg_in.penalty_gain  = csr_wdata;
            CSR_PENALTY_RECIP: cfg_in.penalty_recip = csr_wdata;
            CSR_MIN_FRAMES:    cfg_in.min_frames    = csr_wdata[FRAME_W-1:0];
            CSR_MAX_FRAMES:    cfg_in.max_frames    = csr_wdata[FRAME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.penalty_gain  <= GAIN_RESET;
         cfg_ff.penalty_recip <= RECIP_RESET;
         cfg_ff.min_frames    <= MIN_FRAMES_RESET;
         cfg_ff.max_frames    <= MAX_FRAMES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept, drop action 3 and out of range codes, tag with an op
   pgcp_front #(
      .VOCAB_SIZE (VOCAB_SIZE)
   ) u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_code_index (req_code_index),
      .req_logit      (req_logit),
      .q_status       (q_status),
      .clearing       (clearing),
      .push           (push),
      .push_item      (push_item)
   );

   // decouples the front from back-pressure on results
   pgcp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (q_item),
      .status    (q_status)
   );

   // back: penalty, argmax, eos decision, seen map, result register
   pgcp_back #(
      .VOCAB_SIZE       (VOCAB_SIZE),
      .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_status         (q_status),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .clearing         (clearing),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_chosen_code  (rsp_chosen_code),
      .rsp_status       (rsp_status),
      .rsp_frame_number (rsp_frame_number)
   );

endmodule

`default_nettype wire

// ===== rtl/pgcp_checker.sv =====
// port-level checks of the code picker and their bind to the top level
`default_nettype none

module pgcp_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_stall,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic [pgcp_pkg::CODE_W-1:0]    rsp_chosen_code,
   input wire logic [pgcp_pkg::STATUS_W-1:0]  rsp_status,
   input wire logic [pgcp_pkg::FRAME_W-1:0]   rsp_frame_number
);
   import pgcp_pkg::*;

   // a stalled result word stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   // and keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_chosen_code) && $stable(rsp_status)
                                 && $stable(rsp_frame_number))
      else $error("result payload changed while stalled");

   // eos closes carry no code
   a_eos_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_EOS) |-> rsp_chosen_code == '0)
      else $error("eos result with nonzero code");

   // seen map sweep right after reset keeps the input closed
   a_sweep_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("input open before seen map sweep");

endmodule

bind penalized_greedy_code_picker pgcp_checker u_pgcp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_chosen_code  (rsp_chosen_code),
   .rsp_status       (rsp_status),
   .rsp_frame_number (rsp_frame_number)
);

`default_nettype wire
